### rtl/nbgs_pkg.sv
// Shared types and constants of the two-dimensional gravity stepper.
package nbgs_pkg;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W      = 1;
    localparam logic REG_BODY_COUNT = 1'b0;
    localparam logic REG_WALL_LIMIT = 1'b1;

    localparam logic [3:0]  BODY_COUNT_RST = 4'd2;
    localparam logic [30:0] WALL_LIMIT_RST = 31'h4000_0000;

    // Pull magnitude saturates to the largest Q1.30 value
    localparam logic [30:0] PULL_MAX   = 31'h7FFF_FFFF;
    // gm (Q-8.40) shifted into the Q2.60 frame of d squared, less the Q1.30 result
    localparam int          PULL_SHIFT = 19;
    // Remaining numerator bits of the pull division once the top is preloaded
    localparam logic [6:0]  PULL_STEPS = 7'd31;
    // Full 64-bit numerator for a component division
    localparam logic [6:0]  COMP_STEPS = 7'd64;

    typedef struct packed {
        logic               command;
        logic [2:0]         body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        gm_scaled;
        logic [30:0]        display_radius;
        logic [30:0]        contact_radius;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic               last_body;
    } res_t;

    // One entry of the body table
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        gm;
        logic [30:0]        disp_r;
        logic [30:0]        contact_r;
    } body_t;

    // Request to the shared divider
    typedef struct packed {
        logic        start;
        logic [6:0]  steps;
        logic [63:0] rem_init;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

endpackage

### rtl/nbody_gravity_step.sv
// Two-dimensional gravity stepper: loads a body table and advances it one tick per command.
//
// A load command gives no result and busy stays low. A tick command with any bodies
// in use raises busy and walks them in index order. For each body the table RAM
// is read once per other body for the gravity pass and once more for the overlap pass;
// each visit runs a bit-serial square root (a gravity visit to a coincident body skips
// it), and a gravity visit that is not cut off adds a pull division, unless the pull
// saturates, and two component divisions on the shared divider. Each body's updated
// state appears on result for exactly one cycle with result_valid high; the receiver
// must take it then, as there is no back-pressure.
// Configuration writes are always accepted and must be made while busy is low.
module nbody_gravity_step #(
    parameter int MAX_BODIES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  nbgs_pkg::cmd_t                     cmd,
    output logic                               result_valid,
    output nbgs_pkg::res_t                     result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nbgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [30:0]                        cfg_data
);

    localparam int IW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int BW = $bits(nbgs_pkg::body_t);

    localparam logic PH_GRAV = 1'b0;
    localparam logic PH_OVL  = 1'b1;
    localparam logic AX_X    = 1'b0;
    localparam logic AX_Y    = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_I, S_CAP_I, S_RD_J, S_CAP_J, S_MUL_X, S_MUL_Y, S_SUM, S_SQRT,
        S_CHK, S_PULL, S_CMUL, S_CSTART, S_CDIV, S_MOVE, S_WALL, S_EMIT
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        j_reg;
    logic [CW-1:0]        n_reg;
    logic                 phase_reg;
    logic                 axis_reg;
    logic [3:0]           body_count_reg;
    logic [30:0]          wall_limit_reg;
    logic                 result_valid_reg;
    nbgs_pkg::res_t       result_reg;
    nbgs_pkg::div_req_t   div_req_reg;
    nbgs_pkg::div_rsp_t   div_rsp;

    nbgs_pkg::body_t      cur_reg;
    nbgs_pkg::body_t      oth_reg;
    logic                 dx_neg_reg;
    logic                 dy_neg_reg;
    logic [31:0]          mx_reg;
    logic [31:0]          my_reg;
    logic [63:0]          prod_reg;
    logic [63:0]          acc_reg;
    logic [63:0]          d2_reg;
    logic [63:0]          sq_n_reg;
    logic [63:0]          sq_res_reg;
    logic [63:0]          sq_bit_reg;
    logic [30:0]          a_reg;

    logic [MAX_BODIES-1:0] valid_reg;
    logic                  rvalid_reg;
    logic [BW-1:0]         ram_rdata;
    logic                  we;
    logic [IW-1:0]         waddr;
    nbgs_pkg::body_t       wdata;
    logic [IW-1:0]         raddr;
    nbgs_pkg::body_t       rd_body;

    logic [CW-1:0]         n_eff;
    logic signed [31:0]    dx;
    logic signed [31:0]    dy;
    logic [63:0]           d2_sum;
    logic [63:0]           sq_try;
    logic [31:0]           d;
    logic [31:0]           contact_sum;
    logic [31:0]           disp_sum;
    logic                  ovl_hit;
    logic [63:0]           gm_wide;
    logic [30:0]           comp_m;
    logic [63:0]           wall_y;
    logic [63:0]           wall_x;

    // Saturate a 33-bit signed value to the word range
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -33'sh0_8000_0000)
        begin
            r = -32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        return sat33(33'sd0 - {v[31], v});
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Clamp one axis at the walls; returns {position, velocity}
    function automatic logic [63:0] wall_axis(input logic signed [31:0] p,
                                              input logic signed [31:0] v,
                                              input logic [30:0] r,
                                              input logic [30:0] w);
        logic signed [33:0] pe;
        logic signed [33:0] re;
        logic signed [33:0] we_;
        logic signed [33:0] np;
        logic signed [31:0] po;
        logic signed [31:0] vo;
        pe  = {{2{p[31]}}, p};
        re  = $signed({3'b000, r});
        we_ = $signed({3'b000, w});
        po  = p;
        vo  = v;
        if (pe - re < -we_)
        begin
            np = re - we_;
            po = np[31:0];
            vo = neg_sat(v);
        end
        else if (pe + re > we_)
        begin
            np = we_ - re;
            po = np[31:0];
            vo = neg_sat(v);
        end
        return {po, vo};
    endfunction

    // Body table
    nbgs_ram #(
        .WIDTH(BW),
        .DEPTH(MAX_BODIES)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    nbgs_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req_reg),
        .rsp  (div_rsp)
    );

    // Entries never written read as zero
    assign rd_body = rvalid_reg ? nbgs_pkg::body_t'(ram_rdata) : '0;
    assign raddr   = (state_reg == S_RD_I) ? i_reg[IW-1:0] : j_reg[IW-1:0];

    // Datapath helpers
    always_comb
    begin
        n_eff       = (int'(body_count_reg) > MAX_BODIES) ? CW'(MAX_BODIES)
                                                          : CW'(body_count_reg);
        dx          = sat33({rd_body.px[31], rd_body.px} - {cur_reg.px[31], cur_reg.px});
        dy          = sat33({rd_body.py[31], rd_body.py} - {cur_reg.py[31], cur_reg.py});
        d2_sum      = acc_reg + prod_reg;
        sq_try      = sq_res_reg + sq_bit_reg;
        d           = sq_res_reg[31:0];
        contact_sum = {1'b0, cur_reg.contact_r} + {1'b0, oth_reg.contact_r};
        disp_sum    = {1'b0, cur_reg.disp_r} + {1'b0, oth_reg.disp_r};
        ovl_hit     = disp_sum > d;
        gm_wide     = {13'b0, oth_reg.gm, 19'b0};
        comp_m      = div_rsp.quot[30:0];
        wall_y      = wall_axis(cur_reg.py, cur_reg.vy, cur_reg.disp_r, wall_limit_reg);
        wall_x      = wall_axis(cur_reg.px, cur_reg.vx, cur_reg.disp_r, wall_limit_reg);
    end

    // Table write port: loads, overlap bounce of the other body, final write-back
    always_comb
    begin
        we    = 1'b0;
        waddr = i_reg[IW-1:0];
        wdata = cur_reg;
        if (state_reg == S_IDLE && start && cmd.command == nbgs_pkg::CMD_LOAD
            && int'(cmd.body_index) < MAX_BODIES)
        begin
            we              = 1'b1;
            waddr           = IW'(cmd.body_index);
            wdata.px        = cmd.pos_x;
            wdata.py        = cmd.pos_y;
            wdata.vx        = cmd.vel_x;
            wdata.vy        = cmd.vel_y;
            wdata.gm        = cmd.gm_scaled;
            wdata.disp_r    = cmd.display_radius;
            wdata.contact_r = cmd.contact_radius;
        end
        else if (state_reg == S_CHK && phase_reg == PH_OVL && ovl_hit)
        begin
            we       = 1'b1;
            waddr    = j_reg[IW-1:0];
            wdata    = oth_reg;
            wdata.vx = neg_sat(oth_reg.vx);
            wdata.vy = neg_sat(oth_reg.vy);
        end
        else if (state_reg == S_EMIT)
        begin
            we = 1'b1;
        end
    end

    // Written marks and read-side mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            n_reg            <= '0;
            phase_reg        <= PH_GRAV;
            axis_reg         <= AX_X;
            body_count_reg   <= nbgs_pkg::BODY_COUNT_RST;
            wall_limit_reg   <= nbgs_pkg::WALL_LIMIT_RST;
            result_valid_reg <= 1'b0;
            div_req_reg      <= '0;
        end
        else
        begin
            result_valid_reg  <= 1'b0;
            div_req_reg.start <= 1'b0;

            // Configuration word
            if (cfg_valid)
            begin
                case (cfg_index)
                    nbgs_pkg::REG_BODY_COUNT: body_count_reg <= cfg_data[3:0];
                    nbgs_pkg::REG_WALL_LIMIT: wall_limit_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start && cmd.command == nbgs_pkg::CMD_TICK)
                    begin
                        n_reg <= n_eff;
                        i_reg <= '0;
                        if (n_eff != '0)
                        begin
                            state_reg <= S_RD_I;
                        end
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_CAP_I;
                end
                S_CAP_I:
                begin
                    cur_reg   <= rd_body;
                    j_reg     <= '0;
                    phase_reg <= PH_GRAV;
                    state_reg <= S_RD_J;
                end
                // Pick the next other body, or leave the pass
                S_RD_J:
                begin
                    if (j_reg == n_reg)
                    begin
                        state_reg <= (phase_reg == PH_OVL) ? S_EMIT : S_MOVE;
                    end
                    else if (j_reg == i_reg)
                    begin
                        j_reg <= CW'(j_reg + 1'b1);
                    end
                    else
                    begin
                        state_reg <= S_CAP_J;
                    end
                end
                S_CAP_J:
                begin
                    oth_reg    <= rd_body;
                    dx_neg_reg <= dx[31];
                    dy_neg_reg <= dy[31];
                    mx_reg     <= mag32(dx);
                    my_reg     <= mag32(dy);
                    state_reg  <= S_MUL_X;
                end
                S_MUL_X:
                begin
                    prod_reg  <= mx_reg * mx_reg;
                    state_reg <= S_MUL_Y;
                end
                S_MUL_Y:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= my_reg * my_reg;
                    state_reg <= S_SUM;
                end
                // Coincident bodies pull nothing
                S_SUM:
                begin
                    if (phase_reg == PH_GRAV && d2_sum == '0)
                    begin
                        j_reg     <= CW'(j_reg + 1'b1);
                        state_reg <= S_RD_J;
                    end
                    else
                    begin
                        d2_reg     <= d2_sum;
                        sq_n_reg   <= d2_sum;
                        sq_res_reg <= '0;
                        sq_bit_reg <= 64'h4000_0000_0000_0000;
                        state_reg  <= S_SQRT;
                    end
                end
                // One result bit of the square root per cycle
                S_SQRT:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        if (sq_n_reg >= sq_try)
                        begin
                            sq_n_reg   <= sq_n_reg - sq_try;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                        begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end
                S_CHK:
                begin
                    if (phase_reg == PH_OVL)
                    begin
                        // Bounce both bodies where the display discs overlap
                        if (ovl_hit)
                        begin
                            cur_reg.vx <= neg_sat(cur_reg.vx);
                            cur_reg.vy <= neg_sat(cur_reg.vy);
                        end
                        j_reg     <= CW'(j_reg + 1'b1);
                        state_reg <= S_RD_J;
                    end
                    else if (d < contact_sum)
                    begin
                        j_reg     <= CW'(j_reg + 1'b1);
                        state_reg <= S_RD_J;
                    end
                    else if (gm_wide >= d2_reg)
                    begin
                        a_reg     <= nbgs_pkg::PULL_MAX;
                        axis_reg  <= AX_X;
                        state_reg <= S_CMUL;
                    end
                    else
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.steps    <= nbgs_pkg::PULL_STEPS;
                        div_req_reg.rem_init <= gm_wide;
                        div_req_reg.num      <= '0;
                        div_req_reg.den      <= d2_reg;
                        state_reg            <= S_PULL;
                    end
                end
                S_PULL:
                begin
                    if (div_rsp.done)
                    begin
                        a_reg     <= div_rsp.quot[30:0];
                        axis_reg  <= AX_X;
                        state_reg <= S_CMUL;
                    end
                end
                S_CMUL:
                begin
                    prod_reg  <= a_reg * ((axis_reg == AX_Y) ? my_reg : mx_reg);
                    state_reg <= S_CSTART;
                end
                S_CSTART:
                begin
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.steps    <= nbgs_pkg::COMP_STEPS;
                    div_req_reg.rem_init <= '0;
                    div_req_reg.num      <= prod_reg;
                    div_req_reg.den      <= {32'b0, d};
                    state_reg            <= S_CDIV;
                end
                // Add the pull component along the direction to the other body
                S_CDIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (axis_reg == AX_X)
                        begin
                            cur_reg.vx <= add_sat(cur_reg.vx, dx_neg_reg
                                ? -$signed({1'b0, comp_m}) : $signed({1'b0, comp_m}));
                            axis_reg   <= AX_Y;
                            state_reg  <= S_CMUL;
                        end
                        else
                        begin
                            cur_reg.vy <= add_sat(cur_reg.vy, dy_neg_reg
                                ? -$signed({1'b0, comp_m}) : $signed({1'b0, comp_m}));
                            j_reg      <= CW'(j_reg + 1'b1);
                            state_reg  <= S_RD_J;
                        end
                    end
                end
                S_MOVE:
                begin
                    cur_reg.px <= add_sat(cur_reg.px, cur_reg.vx);
                    cur_reg.py <= add_sat(cur_reg.py, cur_reg.vy);
                    state_reg  <= S_WALL;
                end
                S_WALL:
                begin
                    cur_reg.py <= wall_y[63:32];
                    cur_reg.vy <= wall_y[31:0];
                    cur_reg.px <= wall_x[63:32];
                    cur_reg.vx <= wall_x[31:0];
                    phase_reg  <= PH_OVL;
                    j_reg      <= '0;
                    state_reg  <= S_RD_J;
                end
                // Write the body back and present its word
                S_EMIT:
                begin
                    result_reg.out_index <= 3'(i_reg);
                    result_reg.out_pos_x <= cur_reg.px;
                    result_reg.out_pos_y <= cur_reg.py;
                    result_reg.out_vel_x <= cur_reg.vx;
                    result_reg.out_vel_y <= cur_reg.vy;
                    result_reg.last_body <= (CW'(i_reg + 1'b1) == n_reg);
                    result_valid_reg     <= 1'b1;
                    if (CW'(i_reg + 1'b1) == n_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= CW'(i_reg + 1'b1);
                        state_reg <= S_RD_I;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/nbgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nbgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/nbgs_div.sv
// Restoring divider, one quotient bit per cycle, shared by the pull and component paths.
module nbgs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  nbgs_pkg::div_req_t req,
    output nbgs_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg;
    logic [63:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] quot_reg;
    logic [6:0]  cnt_reg;
    logic        active_reg;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    // Shift in the next numerator bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, num_reg[63]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (req.start)
        begin
            rem_reg    <= req.rem_init;
            num_reg    <= req.num;
            den_reg    <= req.den;
            quot_reg   <= '0;
            cnt_reg    <= req.steps;
            active_reg <= 1'b1;
        end
        else if (active_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg  <= ge ? diff[63:0] : trial[63:0];
                num_reg  <= {num_reg[62:0], 1'b0};
                quot_reg <= {quot_reg[62:0], ge};
                cnt_reg  <= cnt_reg - 7'd1;
            end
            else
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = active_reg && (cnt_reg == '0);
    assign rsp.quot = quot_reg;

endmodule

### verif/tb_nbody_gravity_step.sv
// Self-checking testbench for the two-dimensional gravity stepper.
`timescale 1ns / 100ps

module tb_nbody_gravity_step;

    localparam int     TBL_DEPTH = 8;
    localparam longint WORD_HI   = 64'sd2147483647;
    localparam longint WORD_LO   = -64'sd2147483648;
    localparam int     SETTLE    = 40;

    typedef struct {
        bit                             is_cfg;
        nbgs_pkg::cmd_t                 word;
        logic [nbgs_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [30:0]                    reg_val;
    } action_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    nbgs_pkg::cmd_t                 cmd;
    logic                           result_valid;
    nbgs_pkg::res_t                 result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [nbgs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [30:0]                    cfg_data;

    action_t        pending_q[$];
    nbgs_pkg::res_t body_state_q[$];
    int             mismatches;
    int             accepted_words;

    // Predicted body table and registers
    longint          tbl_px[TBL_DEPTH];
    longint          tbl_py[TBL_DEPTH];
    longint          tbl_vx[TBL_DEPTH];
    longint          tbl_vy[TBL_DEPTH];
    longint unsigned tbl_gm[TBL_DEPTH];
    longint unsigned tbl_disp_r[TBL_DEPTH];
    longint unsigned tbl_contact_r[TBL_DEPTH];
    logic [3:0]      pred_count;
    logic [30:0]     pred_wall;

    nbody_gravity_step #(.MAX_BODIES(TBL_DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint clamp_word(longint v);
        if (v > WORD_HI) return WORD_HI;
        if (v < WORD_LO) return WORD_LO;
        return v;
    endfunction

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // floor(gm * 2^50 / d2), held at the largest Q1.30 value
    function automatic longint unsigned pull_accel(longint unsigned gm, longint unsigned d2);
        longint unsigned rem;
        longint unsigned q;
        longint unsigned nb;
        rem = 0;
        q = 0;
        if ((gm << nbgs_pkg::PULL_SHIFT) >= d2) return longint'(nbgs_pkg::PULL_MAX);
        for (int k = 81; k >= 0; k--)
        begin
            nb = (k >= 50) ? ((gm >> (k - 50)) & 64'd1) : 64'd0;
            rem = (rem << 1) | nb;
            if (rem >= d2)
            begin
                rem = rem - d2;
                if (k < 63) q = q | (64'd1 << k);
            end
        end
        return (q > longint'(nbgs_pkg::PULL_MAX)) ? longint'(nbgs_pkg::PULL_MAX) : q;
    endfunction

    function automatic longint unsigned separation_sq(int i, int j,
                                                      output longint dx, output longint dy);
        dx = clamp_word(tbl_px[j] - tbl_px[i]);
        dy = clamp_word(tbl_py[j] - tbl_py[i]);
        return magn(dx) * magn(dx) + magn(dy) * magn(dy);
    endfunction

    function automatic longint pull_part(longint unsigned a, longint dc, longint unsigned d);
        longint unsigned m;
        m = (a * magn(dc)) / d;
        return (dc < 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic bounce_wall(inout longint p, inout longint v, input longint r,
                               input longint w);
        if (p - r < -w)
        begin
            p = clamp_word(-w + r);
            v = clamp_word(-v);
        end
        else if (p + r > w)
        begin
            p = clamp_word(w - r);
            v = clamp_word(-v);
        end
    endtask

    task automatic advance_body(int i, int n);
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned d;
        longint unsigned a;
        // gravity from every other body that is not coincident and is beyond contact range
        for (int j = 0; j < n; j++)
        begin
            if (j == i) continue;
            d2 = separation_sq(i, j, dx, dy);
            if (d2 == 0) continue;
            d = int_sqrt(d2);
            if (d < tbl_contact_r[i] + tbl_contact_r[j]) continue;
            a = pull_accel(tbl_gm[j], d2);
            tbl_vx[i] = clamp_word(tbl_vx[i] + pull_part(a, dx, d));
            tbl_vy[i] = clamp_word(tbl_vy[i] + pull_part(a, dy, d));
        end
        tbl_px[i] = clamp_word(tbl_px[i] + tbl_vx[i]);
        tbl_py[i] = clamp_word(tbl_py[i] + tbl_vy[i]);
        bounce_wall(tbl_py[i], tbl_vy[i], longint'(tbl_disp_r[i]), longint'(pred_wall));
        bounce_wall(tbl_px[i], tbl_vx[i], longint'(tbl_disp_r[i]), longint'(pred_wall));
        // overlapping display discs reverse both bodies
        for (int j = 0; j < n; j++)
        begin
            if (j == i) continue;
            d2 = separation_sq(i, j, dx, dy);
            d = int_sqrt(d2);
            if (tbl_disp_r[i] + tbl_disp_r[j] > d)
            begin
                tbl_vx[i] = clamp_word(-tbl_vx[i]);
                tbl_vy[i] = clamp_word(-tbl_vy[i]);
                tbl_vx[j] = clamp_word(-tbl_vx[j]);
                tbl_vy[j] = clamp_word(-tbl_vy[j]);
            end
        end
    endtask

    task automatic predict_word(nbgs_pkg::cmd_t w);
        int             n;
        int             k;
        nbgs_pkg::res_t r;
        if (w.command == nbgs_pkg::CMD_LOAD)
        begin
            k = w.body_index;
            if (k >= TBL_DEPTH) return;
            tbl_px[k] = longint'(w.pos_x);
            tbl_py[k] = longint'(w.pos_y);
            tbl_vx[k] = longint'(w.vel_x);
            tbl_vy[k] = longint'(w.vel_y);
            tbl_gm[k] = w.gm_scaled;
            tbl_disp_r[k] = w.display_radius;
            tbl_contact_r[k] = w.contact_radius;
            return;
        end
        n = (pred_count > TBL_DEPTH) ? TBL_DEPTH : pred_count;
        for (int i = 0; i < n; i++)
        begin
            advance_body(i, n);
            r.out_index = i[2:0];
            r.out_pos_x = tbl_px[i][31:0];
            r.out_pos_y = tbl_py[i][31:0];
            r.out_vel_x = tbl_vx[i][31:0];
            r.out_vel_y = tbl_vy[i][31:0];
            r.last_body = (i == n - 1);
            body_state_q.push_back(r);
        end
    endtask

    // Driver: present queued words, pausing at random; register writes wait for idle
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit      taken;
        bit      cfg_taken;
        bit      start_n;
        bit      cfg_n;
        int      settle;
        action_t a;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            settle = 0;
            accepted_words = 0;
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                tbl_px[i] = 0; tbl_py[i] = 0; tbl_vx[i] = 0; tbl_vy[i] = 0;
                tbl_gm[i] = 0; tbl_disp_r[i] = 0; tbl_contact_r[i] = 0;
            end
            pred_count = nbgs_pkg::BODY_COUNT_RST;
            pred_wall = nbgs_pkg::WALL_LIMIT_RST;
        end
        else
        begin
            taken = start && !busy;
            cfg_taken = cfg_valid && cfg_ready;
            if (taken)
            begin
                predict_word(cmd);
                accepted_words++;
            end
            if (cfg_taken)
            begin
                if (cfg_index == nbgs_pkg::REG_BODY_COUNT) pred_count = cfg_data[3:0];
                else pred_wall = cfg_data;
            end
            start_n = start && !taken;
            cfg_n = cfg_valid && !cfg_taken;
            if (!start_n && !cfg_n && pending_q.size() > 0)
            begin
                if (pending_q[0].is_cfg)
                begin
                    if (body_state_q.size() == 0 && !busy && !taken) settle++;
                    else settle = 0;
                    if (settle >= SETTLE)
                    begin
                        a = pending_q.pop_front();
                        cfg_n = 1'b1;
                        cfg_index <= a.reg_idx;
                        cfg_data <= a.reg_val;
                        settle = 0;
                    end
                end
                else if ((accepted_words >= 60 && accepted_words < 95)
                         || $urandom_range(0, 99) >= 25)
                begin
                    a = pending_q.pop_front();
                    start_n = 1'b1;
                    cmd <= a.word;
                end
            end
            start <= start_n;
            cfg_valid <= cfg_n;
        end
    end

    // Monitor: compare each result word with the oldest predicted body state
    always @(posedge clk)
    begin : monitor
        nbgs_pkg::res_t want;
        if (rst_n && result_valid)
        begin
            if (body_state_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: idx %0d pos %h %h vel %h %h last %b",
                             result.out_index, result.out_pos_x, result.out_pos_y,
                             result.out_vel_x, result.out_vel_y, result.last_body);
            end
            else
            begin
                want = body_state_q.pop_front();
                if (want.out_index !== result.out_index || want.out_pos_x !== result.out_pos_x
                    || want.out_pos_y !== result.out_pos_y
                    || want.out_vel_x !== result.out_vel_x
                    || want.out_vel_y !== result.out_vel_y
                    || want.last_body !== result.last_body)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch idx exp %0d got %0d | pos exp %h %h got %h %h | vel exp %h %h got %h %h | last exp %b got %b",
                                 want.out_index, result.out_index,
                                 want.out_pos_x, want.out_pos_y,
                                 result.out_pos_x, result.out_pos_y,
                                 want.out_vel_x, want.out_vel_y,
                                 result.out_vel_x, result.out_vel_y,
                                 want.last_body, result.last_body);
                end
            end
        end
    end

    task automatic queue_reg(logic [nbgs_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
        action_t a;
        a.is_cfg = 1'b1;
        a.word = '0;
        a.reg_idx = idx;
        a.reg_val = val;
        pending_q.push_back(a);
    endtask

    task automatic queue_word(nbgs_pkg::cmd_t w);
        action_t a;
        a.is_cfg = 1'b0;
        a.word = w;
        a.reg_idx = '0;
        a.reg_val = '0;
        pending_q.push_back(a);
    endtask

    task automatic queue_load(int idx, longint px, longint py, longint vx, longint vy,
                              longint unsigned gm, longint unsigned dr, longint unsigned cr);
        nbgs_pkg::cmd_t w;
        w.command = nbgs_pkg::CMD_LOAD;
        w.body_index = idx[2:0];
        w.pos_x = px[31:0];
        w.pos_y = py[31:0];
        w.vel_x = vx[31:0];
        w.vel_y = vy[31:0];
        w.gm_scaled = gm[31:0];
        w.display_radius = dr[30:0];
        w.contact_radius = cr[30:0];
        queue_word(w);
    endtask

    task automatic queue_tick();
        nbgs_pkg::cmd_t w;
        w = nbgs_pkg::cmd_t'({2'b00, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom});
        w.command = nbgs_pkg::CMD_TICK;
        queue_word(w);
    endtask

    // Random body: mostly a plausible orbit-scale body, sometimes raw bit noise
    task automatic queue_random_body();
        nbgs_pkg::cmd_t w;
        if ($urandom_range(0, 3) == 0)
        begin
            w = nbgs_pkg::cmd_t'({2'b00, $urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom});
            w.command = nbgs_pkg::CMD_LOAD;
            queue_word(w);
        end
        else
            queue_load($urandom_range(0, 7),
                       longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000,
                       longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000,
                       longint'($urandom_range(0, 32'h0080_0000)) - 64'sh0040_0000,
                       longint'($urandom_range(0, 32'h0080_0000)) - 64'sh0040_0000,
                       $urandom_range(0, 32'h4000_0000),
                       $urandom_range(0, 32'h0400_0000),
                       $urandom_range(0, 32'h0400_0000));
    endtask

    initial
    begin : stimulus
        int words;
        mismatches = 0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        // Directed: extremes, coincident and far bodies, overlap, counts and walls
        queue_load(0, WORD_HI, WORD_LO, WORD_LO, WORD_HI, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        queue_load(1, WORD_LO, WORD_HI, WORD_HI, WORD_LO, 0, 0, 31'h7FFF_FFFF);
        queue_tick();
        queue_load(0, 64'sh1000_0000, 0, 0, 0, 32'h0100_0000, 0, 0);
        queue_load(1, 64'sh1000_0000, 0, 0, 0, 32'h0100_0000, 0, 0);
        queue_tick();
        queue_load(1, -64'sh1000_0000, 64'sh0800_0000, 64'sh10000, 0, 32'h4000_0000,
                   31'h0100_0000, 31'h0010_0000);
        queue_load(7, 0, 0, 0, 0, 32'hFFFF_FFFF, 31'h2000_0000, 0);
        queue_reg(nbgs_pkg::REG_BODY_COUNT, 31'd8);
        queue_reg(nbgs_pkg::REG_WALL_LIMIT, 31'h7FFF_FFFF);
        queue_tick();
        queue_reg(nbgs_pkg::REG_BODY_COUNT, 31'd0);
        queue_reg(nbgs_pkg::REG_WALL_LIMIT, 31'd0);
        queue_tick();
        queue_reg(nbgs_pkg::REG_BODY_COUNT, 31'd15);
        queue_tick();
        queue_reg(nbgs_pkg::REG_BODY_COUNT, 31'd1);
        queue_reg(nbgs_pkg::REG_WALL_LIMIT, nbgs_pkg::WALL_LIMIT_RST);
        queue_tick();
        words = 14;

        // Random phases: settings, a handful of loads, then ticks
        while (words < 140)
        begin
            if ($urandom_range(0, 4) == 0)
                queue_reg(nbgs_pkg::REG_BODY_COUNT, 31'($urandom_range(0, 15)));
            else
                queue_reg(nbgs_pkg::REG_BODY_COUNT, 31'($urandom_range(2, 5)));
            case ($urandom_range(0, 5))
                0: queue_reg(nbgs_pkg::REG_WALL_LIMIT, 31'd0);
                1: queue_reg(nbgs_pkg::REG_WALL_LIMIT, 31'h7FFF_FFFF);
                2: queue_reg(nbgs_pkg::REG_WALL_LIMIT, 31'($urandom));
                default: queue_reg(nbgs_pkg::REG_WALL_LIMIT,
                                   31'($urandom_range(32'h2000_0000, 32'h4000_0000)));
            endcase
            repeat ($urandom_range(2, 6))
            begin
                queue_random_body();
                words++;
            end
            repeat ($urandom_range(1, 3))
            begin
                queue_tick();
                words++;
            end
        end

        // Drain, then allow for stray words
        while (pending_q.size() > 0 || start || cfg_valid || body_state_q.size() > 0 || busy)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && body_state_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/nbgs_pkg.sv
rtl/nbgs_ram.sv
rtl/nbgs_div.sv
rtl/nbody_gravity_step.sv
verif/tb_nbody_gravity_step.sv
